// File: hdl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg: shared definitions for the binary heap priority queue
// Sizes, heap entry and result layouts, the ranking rule and width helpers.
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int CAPACITY      = 1024;
	localparam int KEY_WIDTH     = 32;
	localparam int HANDLE_WIDTH  = 16;

	// Fixed widths of the key and handle fields on the ports.
	localparam int KEY_PORT_W    = 32;
	localparam int HANDLE_PORT_W = 16;

	// Entry count, heap position (holds 2*CAPACITY+1) and memory address.
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int POS_W  = CNT_W + 1;
	localparam int ADDR_W = $clog2(CAPACITY);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [HANDLE_WIDTH-1:0] hnd;
		logic                    tie;
		logic [KEY_WIDTH-1:0]    key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                     valid_res;
		logic                     full_res;
		logic [HANDLE_PORT_W-1:0] handle;
		logic [KEY_PORT_W-1:0]    out_key;
		logic                     out_tie;
	} result_t;

	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] data;
	} mem_wr_t;

	// X outranks Y on a larger key, or on an equal key when X carries the tie flag.
	function automatic logic outranks(entry_t x, entry_t y);
		return (x.key > y.key) || ((x.key == y.key) && x.tie);
	endfunction

	// Heap positions count from one; the memory is addressed from zero.
	function automatic logic [ADDR_W-1:0] pos_to_addr(logic [POS_W-1:0] pos);
		logic [POS_W-1:0] a;
		a = pos - POS_W'(1);
		return a[ADDR_W-1:0];
	endfunction

	function automatic logic [HANDLE_PORT_W-1:0] handle_out(logic [HANDLE_WIDTH-1:0] h);
		logic [HANDLE_WIDTH+HANDLE_PORT_W-1:0] w;
		w = {{HANDLE_PORT_W{1'b0}}, h};
		return w[HANDLE_PORT_W-1:0];
	endfunction

	function automatic logic [KEY_PORT_W-1:0] key_out(logic [KEY_WIDTH-1:0] k);
		logic [KEY_WIDTH+KEY_PORT_W-1:0] w;
		w = {{KEY_PORT_W{1'b0}}, k};
		return w[KEY_PORT_W-1:0];
	endfunction

	function automatic logic [KEY_WIDTH-1:0] key_in(logic [KEY_PORT_W-1:0] k);
		return k[KEY_WIDTH-1:0];
	endfunction

endpackage

// File: hdl/bhpq_ram.sv
// ----------------------------------------------------------------------------
// bhpq_ram: heap slot memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bhpq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 49
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         ra_data,
	output logic [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

// File: hdl/bhpq_out.sv
// ----------------------------------------------------------------------------
// bhpq_out: result register
// Holds one finished result for the output channel so that the sequencer can
// return to idle while the result waits to be taken.
// ----------------------------------------------------------------------------
module bhpq_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bhpq_pkg::result_t res,
	output logic              rdy,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [55:0]       m_axis_tdata,
	output logic [1:0]        m_axis_tuser
);

	logic              valid_q;
	bhpq_pkg::result_t res_q;

	assign rdy = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
		end else begin
			if (rdy) begin
				valid_q <= push;
				if (push) begin
					res_q <= res;
				end
			end
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {7'b0, res_q.out_tie, res_q.out_key, res_q.handle};
	assign m_axis_tuser  = {res_q.full_res, res_q.valid_res};

endmodule

// File: hdl/bhpq_ctrl.sv
// ----------------------------------------------------------------------------
// bhpq_ctrl: heap sequencer
// Walks the heap in the slot memory for sift-up on insert and sift-down on pop.
// ----------------------------------------------------------------------------
module bhpq_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_cmd,
	input  logic [bhpq_pkg::KEY_PORT_W-1:0]     in_key,
	input  logic                                in_tie,
	input  bhpq_pkg::entry_t                    rd_a,
	input  bhpq_pkg::entry_t                    rd_b,
	output logic [bhpq_pkg::ADDR_W-1:0]         rd_a_addr,
	output logic [bhpq_pkg::ADDR_W-1:0]         rd_b_addr,
	output bhpq_pkg::mem_wr_t                   wr,
	output logic                                push,
	output bhpq_pkg::result_t                   res,
	input  logic                                out_rdy
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_POP_RD,
		ST_POP_LD,
		ST_DN_RD,
		ST_DN_CMP,
		ST_FIN,
		ST_RES
	} state_t;

	state_t                              state_q;
	logic [bhpq_pkg::CNT_W-1:0]          count_q;
	logic [bhpq_pkg::HANDLE_WIDTH-1:0]   nhnd_q;
	logic [bhpq_pkg::POS_W-1:0]          pos_q;
	logic [bhpq_pkg::POS_W-1:0]          jpos_q;
	bhpq_pkg::entry_t                    item_q;
	bhpq_pkg::entry_t                    top_q;
	bhpq_pkg::entry_t                    last_q;
	bhpq_pkg::result_t                   res_q;

	logic [bhpq_pkg::POS_W-1:0]          n_pos;
	logic [bhpq_pkg::POS_W-1:0]          l_pos;
	logic [bhpq_pkg::POS_W-1:0]          r_pos;
	logic [bhpq_pkg::POS_W-1:0]          j_pos;
	logic                                pick_r;
	logic                                j_wins;
	logic                                up_move;
	bhpq_pkg::entry_t                    j_ent;

	assign in_ready = (state_q == ST_IDLE);
	assign push     = (state_q == ST_RES);
	assign res      = res_q;

	always_comb begin
		n_pos   = {1'b0, count_q};
		l_pos   = pos_q << 1;
		r_pos   = l_pos + bhpq_pkg::POS_W'(1);
		// The right child counts only if it lies within the heap.
		pick_r  = (r_pos <= n_pos) && !bhpq_pkg::outranks(rd_a, rd_b);
		j_pos   = pick_r ? r_pos : l_pos;
		j_ent   = pick_r ? rd_b : rd_a;
		j_wins  = pick_r ? bhpq_pkg::outranks(rd_b, last_q)
		                 : bhpq_pkg::outranks(rd_a, last_q);
		up_move = bhpq_pkg::outranks(item_q, rd_a);

		rd_a_addr = bhpq_pkg::pos_to_addr(pos_q >> 1);
		rd_b_addr = bhpq_pkg::pos_to_addr(n_pos);
		wr.en     = 1'b0;
		wr.addr   = bhpq_pkg::pos_to_addr(pos_q);
		wr.data   = item_q;

		case (state_q)
			ST_UP_RD: begin
				wr.en = (pos_q == bhpq_pkg::POS_W'(1));
			end
			ST_UP_CMP: begin
				wr.en   = 1'b1;
				wr.data = up_move ? rd_a : item_q;
			end
			ST_POP_RD: begin
				rd_a_addr = bhpq_pkg::pos_to_addr(bhpq_pkg::POS_W'(1));
			end
			ST_DN_RD: begin
				rd_a_addr = bhpq_pkg::pos_to_addr(l_pos);
				rd_b_addr = bhpq_pkg::pos_to_addr(r_pos);
			end
			ST_DN_CMP: begin
				wr.en   = 1'b1;
				wr.data = j_ent;
			end
			ST_FIN: begin
				wr.en   = 1'b1;
				wr.addr = bhpq_pkg::pos_to_addr(jpos_q >> 1);
				wr.data = last_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			nhnd_q  <= bhpq_pkg::HANDLE_WIDTH'(1);
			pos_q   <= '0;
			jpos_q  <= '0;
			item_q  <= '0;
			top_q   <= '0;
			last_q  <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_cmd == bhpq_pkg::CMD_POP) begin
							res_q   <= '0;
							state_q <= (count_q == '0) ? ST_RES : ST_POP_RD;
						end else if (count_q >= bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY)) begin
							res_q.valid_res <= 1'b0;
							res_q.full_res  <= 1'b1;
							res_q.handle    <= '0;
							res_q.out_key   <= '0;
							res_q.out_tie   <= 1'b0;
							state_q         <= ST_RES;
						end else begin
							res_q      <= '0;
							item_q.key <= bhpq_pkg::key_in(in_key);
							item_q.tie <= in_tie;
							item_q.hnd <= nhnd_q;
							pos_q      <= n_pos + bhpq_pkg::POS_W'(1);
							state_q    <= ST_UP_RD;
						end
					end
				end
				ST_UP_RD: begin
					if (pos_q == bhpq_pkg::POS_W'(1)) begin
						count_q         <= count_q + bhpq_pkg::CNT_W'(1);
						nhnd_q          <= nhnd_q + bhpq_pkg::HANDLE_WIDTH'(1);
						res_q.valid_res <= 1'b1;
						res_q.handle    <= bhpq_pkg::handle_out(item_q.hnd);
						state_q         <= ST_RES;
					end else begin
						state_q <= ST_UP_CMP;
					end
				end
				ST_UP_CMP: begin
					if (up_move) begin
						pos_q   <= pos_q >> 1;
						state_q <= ST_UP_RD;
					end else begin
						count_q         <= count_q + bhpq_pkg::CNT_W'(1);
						nhnd_q          <= nhnd_q + bhpq_pkg::HANDLE_WIDTH'(1);
						res_q.valid_res <= 1'b1;
						res_q.handle    <= bhpq_pkg::handle_out(item_q.hnd);
						state_q         <= ST_RES;
					end
				end
				ST_POP_RD: begin
					state_q <= ST_POP_LD;
				end
				ST_POP_LD: begin
					top_q   <= rd_a;
					last_q  <= rd_b;
					pos_q   <= bhpq_pkg::POS_W'(1);
					jpos_q  <= bhpq_pkg::POS_W'(2);
					state_q <= bhpq_pkg::outranks(rd_a, rd_b) ? ST_DN_RD : ST_FIN;
				end
				ST_DN_RD: begin
					if (l_pos > n_pos) begin
						// No child: the last entry lands at the current position.
						jpos_q  <= l_pos;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DN_CMP;
					end
				end
				ST_DN_CMP: begin
					pos_q   <= j_pos;
					jpos_q  <= j_pos;
					state_q <= j_wins ? ST_DN_RD : ST_FIN;
				end
				ST_FIN: begin
					count_q         <= count_q - bhpq_pkg::CNT_W'(1);
					res_q.valid_res <= 1'b1;
					res_q.handle    <= bhpq_pkg::handle_out(top_q.hnd);
					res_q.out_key   <= bhpq_pkg::key_out(top_q.key);
					res_q.out_tie   <= top_q.tie;
					state_q         <= ST_RES;
				end
				ST_RES: begin
					if (out_rdy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue: max-heap priority queue with handles
// Inserts stamped entries and pops the highest ranked one, keeping the heap
// in an on-chip slot memory.
// ----------------------------------------------------------------------------
//
// Channel   Signals                  Contents (lowest bit first)
// input     s_axis_t{valid,ready}    tuser: command; tdata: key[31:0], tie_wins
// output    m_axis_t{valid,ready}    tuser: valid_res, full_res;
//                                    tdata: handle[15:0], out_key[31:0], out_tie
//
// One command is worked at a time. An insert climbs from the new slot until
// its entry no longer outranks the parent or reaches the root, and a pop
// walks the hole down from the root until the higher ranked child no longer
// outranks the last entry or no child is left. A pop on an empty heap or an
// insert into a full heap goes straight to its result.
// Each level costs one slot memory read (two child slots at once on a pop)
// and one compare-and-write step.
// Reset clears the entry count and sets the next handle to one; the slot
// memory is not cleared, as data from unwritten slots is never used.
// A result waits in an output register, so a stalled output only holds the
// sequencer once a second result is ready.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // key[31:0], tie_wins, zero fill
	input  logic        s_axis_tuser,   // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // handle[15:0], out_key[31:0], out_tie, zero fill
	output logic [1:0]  m_axis_tuser    // valid_res, full_res
);

	bhpq_pkg::entry_t                rd_a;
	bhpq_pkg::entry_t                rd_b;
	logic [bhpq_pkg::ADDR_W-1:0]     rd_a_addr;
	logic [bhpq_pkg::ADDR_W-1:0]     rd_b_addr;
	bhpq_pkg::mem_wr_t               mem_wr;
	bhpq_pkg::result_t               res;
	logic                            push;
	logic                            out_rdy;

	// Sequencer: sift-up on insert, sift-down on pop, a read and a compare-and-write for each level.
	bhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_key    (s_axis_tdata[31:0]),
		.in_tie    (s_axis_tdata[32]),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.wr        (mem_wr),
		.push      (push),
		.res       (res),
		.out_rdy   (out_rdy)
	);

	// Slot memory: both children of a node are read in the same cycle.
	bhpq_ram #(
		.DEPTH (bhpq_pkg::CAPACITY),
		.WIDTH (bhpq_pkg::ENTRY_W)
	) u_ram (
		.clk     (clk),
		.we      (mem_wr.en),
		.waddr   (mem_wr.addr),
		.wdata   (mem_wr.data),
		.ra_addr (rd_a_addr),
		.rb_addr (rd_b_addr),
		.ra_data (rd_a),
		.rb_data (rd_b)
	);

	// Output register for the result transfer.
	bhpq_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.res           (res),
		.rdy           (out_rdy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// The heap is never written while a new command could be taken.
	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> !s_axis_tready)
		else $error("slot memory written while the input is ready");

	// Every accepted command takes the sequencer out of idle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready straight after an accepted transfer");

	// A finished result is not dropped while the output register is occupied.
	a_push_held: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !out_rdy) |=> push)
		else $error("result withdrawn before the output register took it");

	// A dropped insert never also reports success.
	a_full_excludes_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("result flagged both valid and full");

endmodule
